>>> rtl/core/mtep_pkg.sv
// Package for the MIDI track event parser: widths, register indexes, parser
// constants and the command/status structs between controller and datapath.
// No dependencies.
package mtep_pkg;

  localparam int ByteW    = 8;
  localparam int DeltaW   = 28;
  localparam int TimeW    = 32;
  localparam int TempoW   = 16;
  localparam int TpqW     = 15;
  localparam int ProdW    = TimeW + TempoW;
  localparam int RemW     = TpqW;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;
  localparam int StepCntW = $clog2(ProdW);

  localparam logic [CfgIdxW-1:0] RegTempoScale      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTicksPerQuarter = CfgIdxW'(1);

  localparam logic [TempoW-1:0] TempoReset = TempoW'(96);
  localparam logic [TpqW-1:0]   TpqReset   = TpqW'(96);

  localparam logic [ByteW-1:0] MetaStatus     = 8'hFF;
  localparam logic [ByteW-1:0] MetaEndOfTrack = 8'h2F;
  localparam logic [3:0]       NibNoteOff     = 4'h8;
  localparam logic [3:0]       NibProgChange  = 4'hC;
  localparam logic [3:0]       NibChanPress   = 4'hD;

  typedef struct packed {
    logic parse;
    logic mul;
    logic div_step;
    logic load_out;
  } mtep_cmd_t;

  typedef struct packed {
    logic emit;
  } mtep_status_t;

endpackage

>>> rtl/core/mtep_if.sv
// Channel interfaces for the MIDI track event parser: input byte word,
// result word and configuration write. Depends on mtep_pkg.
interface mtep_in_if;
  logic                      valid;
  logic                      ready;
  logic [mtep_pkg::ByteW-1:0] data_byte;
  logic                      track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtep_pkg::ByteW-1:0] status_byte;
  logic [mtep_pkg::ByteW-1:0] first_data;
  logic [mtep_pkg::ByteW-1:0] second_data;
  logic [mtep_pkg::TimeW-1:0] event_time;
  logic                       end_of_track;

  modport source (output valid, output status_byte, output first_data, output second_data,
                  output event_time, output end_of_track, input ready);
  modport sink   (input valid, input status_byte, input first_data, input second_data,
                  input event_time, input end_of_track, output ready);
endinterface

interface mtep_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mtep_pkg::CfgIdxW-1:0]  reg_index;
  logic [mtep_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/core/mtep_ctrl.sv
// Controller for the MIDI track event parser: sequences byte intake, the
// multiply, the bit-serial divide and the result register. Depends on mtep_pkg.
module mtep_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  mtep_pkg::mtep_status_t status_i,
  output mtep_pkg::mtep_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  localparam logic [mtep_pkg::StepCntW-1:0] LastStep =
    mtep_pkg::StepCntW'(mtep_pkg::ProdW - 1);

  logic [1:0]                    state_q, state_d;
  logic [mtep_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.parse = in_valid_i;
        if (in_valid_i && status_i.emit) begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == LastStep) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/mtep_dp.sv
// Datapath for the MIDI track event parser: byte parser registers, config
// registers, tempo multiply, restoring divider and result word. Depends on mtep_pkg.
module mtep_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtep_pkg::mtep_cmd_t            cmd_i,
  output mtep_pkg::mtep_status_t         status_o,
  input  logic                           cfg_valid_i,
  input  logic [mtep_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mtep_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [mtep_pkg::ByteW-1:0]     data_byte_i,
  input  logic                           track_start_i,
  output logic [mtep_pkg::ByteW-1:0]     status_byte_o,
  output logic [mtep_pkg::ByteW-1:0]     first_data_o,
  output logic [mtep_pkg::ByteW-1:0]     second_data_o,
  output logic [mtep_pkg::TimeW-1:0]     event_time_o,
  output logic                           end_of_track_o
);

  localparam logic [2:0] PhDelta    = 3'd0;
  localparam logic [2:0] PhStatus   = 3'd1;
  localparam logic [2:0] PhMetaType = 3'd2;
  localparam logic [2:0] PhMetaLen  = 3'd3;
  localparam logic [2:0] PhMetaSkip = 3'd4;
  localparam logic [2:0] PhData1    = 3'd5;
  localparam logic [2:0] PhData2    = 3'd6;
  localparam logic [2:0] PhEnded    = 3'd7;

  localparam int ByteW  = mtep_pkg::ByteW;
  localparam int DeltaW = mtep_pkg::DeltaW;
  localparam int TimeW  = mtep_pkg::TimeW;
  localparam int ProdW  = mtep_pkg::ProdW;
  localparam int RemW   = mtep_pkg::RemW;

  logic [mtep_pkg::TempoW-1:0] tempo_q;
  logic [mtep_pkg::TpqW-1:0]   tpq_q;

  logic [2:0]       phase_q, phase_d;
  logic [DeltaW-1:0] acc_q, acc_d;
  logic [TimeW-1:0] abs_q, abs_d;
  logic [ByteW-1:0] held_status_q, held_status_d;
  logic [ByteW-1:0] held_first_q, held_first_d;
  logic [ByteW-1:0] meta_type_q, meta_type_d;
  logic [ByteW-1:0] meta_left_q, meta_left_d;

  logic [ByteW-1:0] pend_status_q, pend_status_d;
  logic [ByteW-1:0] pend_first_q, pend_first_d;
  logic [ByteW-1:0] pend_second_q, pend_second_d;
  logic             pend_eot_q, pend_eot_d;

  logic [2:0]        ph_eff;
  logic [DeltaW-1:0] acc_eff, acc_shift;
  logic [TimeW-1:0]  abs_eff;
  logic [ByteW-1:0]  meta_dec;
  logic [3:0]        nib;
  logic              emit;

  logic [ProdW-1:0] quo_q;
  logic [RemW-1:0]  rem_q;
  logic [ProdW-1:0] prod;
  logic [RemW:0]    rem_sh, divisor, rem_sub;
  logic [TimeW-1:0] quo_lo, time_adj;

  logic [ByteW-1:0] out_status_q, out_first_q, out_second_q;
  logic [TimeW-1:0] out_time_q;
  logic             out_eot_q;

  // parser step for one accepted byte
  always_comb begin
    ph_eff    = track_start_i ? PhDelta : phase_q;
    acc_eff   = track_start_i ? '0 : acc_q;
    abs_eff   = track_start_i ? '0 : abs_q;
    acc_shift = {acc_eff[DeltaW-8:0], data_byte_i[6:0]};
    meta_dec  = meta_left_q - 1'b1;
    nib       = held_status_q[7:4];

    phase_d       = phase_q;
    acc_d         = acc_q;
    abs_d         = abs_q;
    held_status_d = held_status_q;
    held_first_d  = held_first_q;
    meta_type_d   = meta_type_q;
    meta_left_d   = meta_left_q;
    pend_status_d = pend_status_q;
    pend_first_d  = pend_first_q;
    pend_second_d = pend_second_q;
    pend_eot_d    = pend_eot_q;
    emit          = 1'b0;

    if (cmd_i.parse) begin
      phase_d = ph_eff;
      acc_d   = acc_eff;
      abs_d   = abs_eff;
      case (ph_eff)
        PhDelta: begin
          if (data_byte_i[7]) begin
            acc_d = acc_shift;
          end else begin
            abs_d   = abs_eff + {{(TimeW-DeltaW){1'b0}}, acc_shift};
            acc_d   = '0;
            phase_d = PhStatus;
          end
        end
        PhStatus: begin
          if (data_byte_i == mtep_pkg::MetaStatus) begin
            phase_d = PhMetaType;
          end else begin
            held_status_d = data_byte_i;
            phase_d       = PhData1;
          end
        end
        PhMetaType: begin
          meta_type_d = data_byte_i;
          phase_d     = PhMetaLen;
        end
        PhMetaLen, PhMetaSkip: begin
          meta_left_d = (ph_eff == PhMetaLen) ? data_byte_i : meta_dec;
          if (ph_eff == PhMetaLen && data_byte_i != '0) begin
            phase_d = PhMetaSkip;
          end else if (meta_left_d == '0) begin
            if (meta_type_q == mtep_pkg::MetaEndOfTrack) begin
              phase_d       = PhEnded;
              emit          = 1'b1;
              pend_status_d = '0;
              pend_first_d  = '0;
              pend_second_d = '0;
              pend_eot_d    = 1'b1;
            end else begin
              phase_d = PhDelta;
            end
          end
        end
        PhData1: begin
          held_first_d = data_byte_i;
          if (nib inside {mtep_pkg::NibProgChange, mtep_pkg::NibChanPress}) begin
            phase_d       = PhDelta;
            emit          = 1'b1;
            pend_status_d = held_status_q;
            pend_first_d  = data_byte_i;
            pend_second_d = '0;
            pend_eot_d    = 1'b0;
          end else begin
            phase_d = PhData2;
          end
        end
        PhData2: begin
          phase_d       = PhDelta;
          emit          = 1'b1;
          pend_status_d = held_status_q;
          pend_first_d  = held_first_q;
          pend_second_d = data_byte_i;
          pend_eot_d    = 1'b0;
        end
        default: phase_d = ph_eff;
      endcase
    end
  end

  assign status_o.emit = emit;

  // scaled time: full product, then one quotient bit per cycle
  assign prod    = {{mtep_pkg::TempoW{1'b0}}, abs_q} * {{TimeW{1'b0}}, tempo_q};
  assign divisor = (tpq_q == '0) ? (RemW+1)'(1) : {1'b0, tpq_q};
  assign rem_sh  = {rem_q, quo_q[ProdW-1]};
  assign rem_sub = rem_sh - divisor;
  assign quo_lo  = quo_q[TimeW-1:0];
  assign time_adj = (pend_status_q[7:4] == mtep_pkg::NibNoteOff && quo_lo != '0) ?
                    quo_lo - 1'b1 : quo_lo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      quo_q <= prod;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= divisor) begin
        rem_q <= rem_sub[RemW-1:0];
        quo_q <= {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[RemW-1:0];
        quo_q <= {quo_q[ProdW-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= pend_status_q;
      out_first_q  <= pend_first_q;
      out_second_q <= pend_second_q;
      out_time_q   <= time_adj;
      out_eot_q    <= pend_eot_q;
    end
    pend_status_q <= pend_status_d;
    pend_first_q  <= pend_first_d;
    pend_second_q <= pend_second_d;
    pend_eot_q    <= pend_eot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q       <= mtep_pkg::TempoReset;
      tpq_q         <= mtep_pkg::TpqReset;
      phase_q       <= PhDelta;
      acc_q         <= '0;
      abs_q         <= '0;
      held_status_q <= '0;
      held_first_q  <= '0;
      meta_type_q   <= '0;
      meta_left_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == mtep_pkg::RegTempoScale) begin
        tempo_q <= cfg_data_i[mtep_pkg::TempoW-1:0];
      end
      if (cfg_valid_i && cfg_index_i == mtep_pkg::RegTicksPerQuarter) begin
        tpq_q <= cfg_data_i[mtep_pkg::TpqW-1:0];
      end
      phase_q       <= phase_d;
      acc_q         <= acc_d;
      abs_q         <= abs_d;
      held_status_q <= held_status_d;
      held_first_q  <= held_first_d;
      meta_type_q   <= meta_type_d;
      meta_left_q   <= meta_left_d;
    end
  end

  assign status_byte_o  = out_status_q;
  assign first_data_o   = out_first_q;
  assign second_data_o  = out_second_q;
  assign event_time_o   = out_time_q;
  assign end_of_track_o = out_eot_q;

endmodule

>>> rtl/core/midi_track_event_parser.sv
// Top level of the MIDI track event parser: joins controller and datapath
// to the channel interfaces. Depends on mtep_pkg, mtep_if, mtep_ctrl, mtep_dp.
//
// Usage: in_i takes the track bytes that follow the chunk header, one word
// per byte; track_start marks the first byte of a track and clears the tick
// count and the parser. out_o gives one word per completed channel message
// or end-of-track meta event. cfg_i writes tempo_scale (index 0) and
// ticks_per_quarter (index 1); it is always ready, and it must be written
// only while idle; the block itself does not enforce this. A byte that
// completes no event leaves the block idle, so such bytes may arrive back
// to back. A byte that completes an event starts the multiply, then the
// restoring divide (one quotient bit per cycle), then the load of the
// result register, and in_i is not ready during that time. The result
// register is separate, so bytes keep flowing while a result waits; if the
// next result is ready before the previous one is taken, the block holds it
// and stops taking bytes until out_o ready returns. Reset clears the parser,
// the tick count and the result valid, and sets both registers to 96.
module midi_track_event_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtep_in_if.sink     in_i,
  mtep_out_if.source  out_o,
  mtep_cfg_if.sink    cfg_i
);

  mtep_pkg::mtep_cmd_t    cmd;
  mtep_pkg::mtep_status_t status;

  assign cfg_i.ready = 1'b1;

  mtep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mtep_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.reg_index),
    .cfg_data_i    (cfg_i.wdata),
    .data_byte_i   (in_i.data_byte),
    .track_start_i (in_i.track_start),
    .status_byte_o (out_o.status_byte),
    .first_data_o  (out_o.first_data),
    .second_data_o (out_o.second_data),
    .event_time_o  (out_o.event_time),
    .end_of_track_o(out_o.end_of_track)
  );

endmodule
